/* src/quaternion_point_rotator_top_assert.svh */
// Assertion macros for the quaternion point rotator.
// Used by quaternion_point_rotator_top.sv; relies on clk and rst in the including scope.
`ifndef QUATERNION_POINT_ROTATOR_TOP_ASSERT_SVH
`define QUATERNION_POINT_ROTATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// a |-> b, checked on every clk edge outside reset
`define QPR_ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("qpr assertion failed");
// a |=> b, checked on every clk edge outside reset
`define QPR_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("qpr assertion failed");
`else
`define QPR_ASSERT_IMPL(label, a, b)
`define QPR_ASSERT_NEXT(label, a, b)
`endif

`endif

/* src/qpr_pkg.sv */
// Constants, types and rounding helpers for the quaternion point rotator.
// No dependencies; imported by quaternion_point_rotator_top.
package qpr_pkg;

  localparam int QUAT_W      = 16;   // Q1.14
  localparam int VEC_W       = 32;   // Q16.16
  localparam int MAT_W       = 18;   // Q1.16
  localparam int MAT_N       = 9;
  localparam int CFG_INDEX_W = 4;
  localparam int BUILD_W     = 35;   // matrix sums at scale 2^28
  localparam int PROD_W      = MAT_W + VEC_W;
  localparam int ACC_W       = PROD_W + 2;

  localparam logic [CFG_INDEX_W-1:0] REG_QUAT_W = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_QUAT_X = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_QUAT_Y = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_QUAT_Z = CFG_INDEX_W'(3);

  localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;
  localparam logic signed [MAT_W-1:0]  MAT_ONE  = 18'sd65536;

  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [MAT_W-1:0]  mat_entry_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // scale 2^28 -> Q1.16, round half up, saturate to 18 bits
  function automatic mat_entry_t to_entry(input logic signed [BUILD_W-1:0] v);
    logic signed [BUILD_W-1:0] t;
    logic signed [BUILD_W-13:0] r;
    mat_entry_t res;
    t = v + BUILD_W'(2048);
    r = (BUILD_W-12)'(t >>> 12);
    if (r > (BUILD_W-12)'(131071))
      res = 18'sd131071;
    else if (r < -(BUILD_W-12)'(131072))
      res = -18'sd131072;
    else
      res = MAT_W'(r);
    return res;
  endfunction

  // scale 2^32 -> Q16.16, round half up, saturate to 32 bits
  function automatic vec_t to_vec(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-17:0] r;
    vec_t res;
    t = acc + ACC_W'(32768);
    r = (ACC_W-16)'(t >>> 16);
    if (r > (ACC_W-16)'(64'sd2147483647))
      res = 32'sh7fffffff;
    else if (r < -(ACC_W-16)'(64'sd2147483648))
      res = 32'sh80000000;
    else
      res = VEC_W'(r);
    return res;
  endfunction

endpackage

/* src/quaternion_point_rotator_top.sv */
// Quaternion point rotator: config registers, matrix build and 3-stage vector pipeline.
// Depends on qpr_pkg and quaternion_point_rotator_top_assert.svh.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes quat_w, quat_x,
//    quat_y, quat_z at indexes 0..3 in signed Q1.14. Other indexes are ignored.
//  - Each write to indexes 0..3 rebuilds the 3x3 rotation matrix: the ten
//    quaternion products are registered, then summed, rounded and saturated to Q1.16.
//    in_stall is held high and cfg_ready low until the new matrix is loaded.
//  - Input channel (in_valid/in_stall) takes one Q16.16 vector word per cycle while in_stall is low.
//  - Output channel (out_valid/out_stall) gives the rotated vector, rounded and
//    saturated to Q16.16.
//  - Path: the input register feeds one 18x32 multiplier per matrix entry into
//    the product register, then three-term sum and rounding into the output
//    register. Throughput is one word per cycle when nothing stalls the input.
//  - When out_stall is high, words hold in the pipeline; in_stall rises once every
//    stage is full, and also while a matrix build is in progress.
//  - Reset (rst, synchronous) loads the unit quaternion, the identity matrix
//    and empties the pipeline.
module quaternion_point_rotator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [qpr_pkg::QUAT_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [qpr_pkg::VEC_W-1:0]  in_x,
  input  logic signed [qpr_pkg::VEC_W-1:0]  in_y,
  input  logic signed [qpr_pkg::VEC_W-1:0]  in_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [qpr_pkg::VEC_W-1:0]  out_x,
  output logic signed [qpr_pkg::VEC_W-1:0]  out_y,
  output logic signed [qpr_pkg::VEC_W-1:0]  out_z
);
  import qpr_pkg::*;

  `include "quaternion_point_rotator_top_assert.svh"

  // configuration and matrix build
  quat_t quat_w, quat_x, quat_y, quat_z;
  logic  build_pending, build_mul, building, cfg_hit;
  logic signed [2*QUAT_W-1:0] p_aa, p_bb, p_cc, p_dd, p_ab, p_ac, p_ad, p_bc, p_bd, p_cd;
  logic signed [BUILD_W-1:0]  ent [MAT_N];
  mat_entry_t mat [MAT_N];

  assign building  = build_pending || build_mul;
  assign cfg_ready = !building;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     (cfg_index == REG_QUAT_W || cfg_index == REG_QUAT_X ||
                      cfg_index == REG_QUAT_Y || cfg_index == REG_QUAT_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w        <= QUAT_ONE;
      quat_x        <= '0;
      quat_y        <= '0;
      quat_z        <= '0;
      build_pending <= 1'b0;
      build_mul     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_QUAT_W: quat_w <= cfg_data;
          REG_QUAT_X: quat_x <= cfg_data;
          REG_QUAT_Y: quat_y <= cfg_data;
          REG_QUAT_Z: quat_z <= cfg_data;
          default: ;
        endcase
      end
      build_pending <= cfg_hit;
      build_mul     <= build_pending;
    end
  end

  always_ff @(posedge clk) begin
    if (build_pending) begin
      p_aa <= quat_w * quat_w;
      p_bb <= quat_x * quat_x;
      p_cc <= quat_y * quat_y;
      p_dd <= quat_z * quat_z;
      p_ab <= quat_w * quat_x;
      p_ac <= quat_w * quat_y;
      p_ad <= quat_w * quat_z;
      p_bc <= quat_x * quat_y;
      p_bd <= quat_x * quat_z;
      p_cd <= quat_y * quat_z;
    end
  end

  always_comb begin
    ent[0] = BUILD_W'(p_aa) + BUILD_W'(p_bb) - BUILD_W'(p_cc) - BUILD_W'(p_dd);
    ent[1] = (BUILD_W'(p_bc) - BUILD_W'(p_ad)) <<< 1;
    ent[2] = (BUILD_W'(p_bd) + BUILD_W'(p_ac)) <<< 1;
    ent[3] = (BUILD_W'(p_bc) + BUILD_W'(p_ad)) <<< 1;
    ent[4] = BUILD_W'(p_aa) - BUILD_W'(p_bb) + BUILD_W'(p_cc) - BUILD_W'(p_dd);
    ent[5] = (BUILD_W'(p_cd) - BUILD_W'(p_ab)) <<< 1;
    ent[6] = (BUILD_W'(p_bd) - BUILD_W'(p_ac)) <<< 1;
    ent[7] = (BUILD_W'(p_cd) + BUILD_W'(p_ab)) <<< 1;
    ent[8] = BUILD_W'(p_aa) - BUILD_W'(p_bb) - BUILD_W'(p_cc) + BUILD_W'(p_dd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAT_N; k++) begin
        mat[k] <= (k == 0 || k == 4 || k == 8) ? MAT_ONE : '0;
      end
    end else if (build_mul) begin
      for (int k = 0; k < MAT_N; k++) begin
        mat[k] <= to_entry(ent[k]);
      end
    end
  end

  // vector pipeline
  logic  v1, v2, free1, free2, free3, in_acc;
  vec_t  x1, y1, z1;
  prod_t prod [MAT_N];
  logic signed [ACC_W-1:0] acc [3];

  assign free3    = !out_valid || !out_stall;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign in_stall = !free1 || building;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free1) begin
        v1 <= in_acc;
      end
      if (free2) begin
        v2 <= v1;
      end
      if (free3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x1 <= in_x;
      y1 <= in_y;
      z1 <= in_z;
    end
    if (free2 && v1) begin
      for (int r = 0; r < 3; r++) begin
        prod[3*r]   <= mat[3*r]   * x1;
        prod[3*r+1] <= mat[3*r+1] * y1;
        prod[3*r+2] <= mat[3*r+2] * z1;
      end
    end
    if (free3 && v2) begin
      out_x <= to_vec(acc[0]);
      out_y <= to_vec(acc[1]);
      out_z <= to_vec(acc[2]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = ACC_W'(prod[3*r]) + ACC_W'(prod[3*r+1]) + ACC_W'(prod[3*r+2]);
    end
  end

  // a quaternion write must block input until the new matrix is in place
  `QPR_ASSERT_NEXT(a_write_blocks_input, cfg_hit, in_stall && build_pending)
  `QPR_ASSERT_NEXT(a_build_sequence, build_pending, build_mul && !build_pending)
  `QPR_ASSERT_NEXT(a_accept_fills_stage1, in_acc, v1)
  `QPR_ASSERT_NEXT(a_no_invented_output, out_valid && !out_stall && !v2, !out_valid)
  `QPR_ASSERT_IMPL(a_no_accept_during_build, building, !in_acc)

endmodule

/* dv/tb_quaternion_point_rotator_top.sv */
// Testbench for quaternion_point_rotator_top: random and directed vectors under several
// quaternion settings, checked against an in-bench matrix predictor.
// Depends on qpr_pkg and the RTL of quaternion_point_rotator_top.
module tb_quaternion_point_rotator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qpr_pkg::*;

  typedef struct packed {
    logic [VEC_W-1:0] x;
    logic [VEC_W-1:0] y;
    logic [VEC_W-1:0] z;
  } rot_vec_t;

  class rotation_predictor;
    quat_t      qw, qx, qy, qz;
    mat_entry_t rot [MAT_N];
    rot_vec_t   rotated_q [$];
    int         bad;

    function new();
      qw  = QUAT_ONE;
      qx  = '0;
      qy  = '0;
      qz  = '0;
      bad = 0;
      rebuild();
    endfunction

    // scale 2^28 -> Q1.16, round half up, saturate to 18 bits
    function mat_entry_t fit_entry(longint v);
      longint t;
      t = (v + 64'sd2048) >>> 12;
      if (t > 64'sd131071) t = 64'sd131071;
      if (t < -64'sd131072) t = -64'sd131072;
      return mat_entry_t'(t);
    endfunction

    function void rebuild();
      longint a, b, c, d;
      a = longint'(qw);
      b = longint'(qx);
      c = longint'(qy);
      d = longint'(qz);
      rot[0] = fit_entry(a*a + b*b - c*c - d*d);
      rot[1] = fit_entry(2 * (b*c - a*d));
      rot[2] = fit_entry(2 * (b*d + a*c));
      rot[3] = fit_entry(2 * (b*c + a*d));
      rot[4] = fit_entry(a*a - b*b + c*c - d*d);
      rot[5] = fit_entry(2 * (c*d - a*b));
      rot[6] = fit_entry(2 * (b*d - a*c));
      rot[7] = fit_entry(2 * (c*d + a*b));
      rot[8] = fit_entry(a*a - b*b - c*c + d*d);
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [QUAT_W-1:0] val);
      case (idx)
        REG_QUAT_W: qw = quat_t'(val);
        REG_QUAT_X: qx = quat_t'(val);
        REG_QUAT_Y: qy = quat_t'(val);
        REG_QUAT_Z: qz = quat_t'(val);
        default: return;  // unmapped index leaves the matrix alone
      endcase
      rebuild();
    endfunction

    function void take_vector(vec_t x, vec_t y, vec_t z);
      longint   acc;
      vec_t     comp [3];
      rot_vec_t res;
      for (int r = 0; r < 3; r++) begin
        acc = longint'(rot[3*r]) * longint'(x) + longint'(rot[3*r+1]) * longint'(y)
            + longint'(rot[3*r+2]) * longint'(z);
        acc = (acc + 64'sd32768) >>> 16;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        comp[r] = vec_t'(acc);
      end
      res.x = comp[0];
      res.y = comp[1];
      res.z = comp[2];
      rotated_q.push_back(res);
    endfunction

    function void match_output(rot_vec_t got);
      rot_vec_t want;
      if (rotated_q.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("tb: unexpected rotated word %h %h %h", got.x, got.y, got.z);
        return;
      end
      want = rotated_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
        bad++;
        if (bad <= 10)
          $display("tb: mismatch exp x=%h y=%h z=%h got x=%h y=%h z=%h",
                   want.x, want.y, want.z, got.x, got.y, got.z);
      end
    endfunction

    function int pending();
      return rotated_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [QUAT_W-1:0]      cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  vec_t                   in_x = '0;
  vec_t                   in_y = '0;
  vec_t                   in_z = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  vec_t                   out_x, out_y, out_z;

  rotation_predictor sb;
  bit                calm = 1'b0;  // no idling on either side while set

  localparam vec_t V_MAX = 32'sh7fffffff;
  localparam vec_t V_MIN = 32'sh80000000;
  localparam logic [CFG_INDEX_W-1:0] QUAT_REGS [4] =
    '{REG_QUAT_W, REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z};

  quaternion_point_rotator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // valid stays high after acceptance; the caller lowers it when the stream pauses
  task automatic send_vec(vec_t x, vec_t y, vec_t z);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x     <= x;
    in_y     <= y;
    in_z     <= z;
    do @(posedge clk); while (in_stall);
    sb.take_vector(x, y, z);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [QUAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // registers change only once the pipeline has drained
  task automatic apply_quat(quat_t w, quat_t x, quat_t y, quat_t z, bit junk);
    quat_t vals [4];
    int    first;
    int    k;
    vals[0] = w;
    vals[1] = x;
    vals[2] = y;
    vals[3] = z;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    first = $urandom_range(0, 3);
    if (junk)
      write_reg(CFG_INDEX_W'($urandom_range(4, 15)), QUAT_W'($urandom));
    for (k = 0; k < 4; k++)
      write_reg(QUAT_REGS[(first + k) % 4], vals[(first + k) % 4]);
    cfg_valid <= 1'b0;
  endtask

  function automatic vec_t pick_comp();
    case ($urandom_range(0, 9))
      0: return V_MAX;
      1: return V_MIN;
      2, 3, 4: return vec_t'(int'($urandom_range(0, 2097152)) - 1048576);
      default: return vec_t'($urandom);
    endcase
  endfunction

  function automatic void random_unit(output quat_t w, output quat_t x,
                                      output quat_t y, output quat_t z);
    real c [4];
    real n;
    do begin
      n = 0.0;
      for (int k = 0; k < 4; k++) begin
        c[k] = (real'(int'($urandom_range(0, 2000))) - 1000.0) / 1000.0;
        n = n + c[k] * c[k];
      end
    end while (n < 0.01);
    n = $sqrt(n);
    w = quat_t'($rtoi(c[0] / n * 16383.0));
    x = quat_t'($rtoi(c[1] / n * 16383.0));
    y = quat_t'($rtoi(c[2] / n * 16383.0));
    z = quat_t'($rtoi(c[3] / n * 16383.0));
  endfunction

  // receiving side
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.match_output({out_x, out_y, out_z});
    end
  end

  initial begin
    quat_t qa, qb, qc, qd;
    int    sent;
    int    n;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity matrix out of reset: words pass through unchanged
    send_vec('0, '0, '0);
    send_vec(V_MAX, V_MIN, 32'sd1);
    send_vec(V_MIN, V_MAX, -32'sd1);
    send_vec(V_MAX, V_MAX, V_MAX);
    send_vec(V_MIN, V_MIN, V_MIN);
    send_vec(32'sh00008000, -32'sh00008000, 32'sh55555555);

    // non-unit quaternion, entries saturate at the positive end
    apply_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_vec(V_MAX, V_MAX, V_MAX);
    send_vec(V_MIN, V_MIN, V_MIN);
    send_vec(V_MAX, V_MIN, V_MAX);
    send_vec(32'sd1, -32'sd1, '0);

    // w at its most negative gives a diagonal of about two
    apply_quat(16'sh8000, '0, '0, '0, 1'b0);
    send_vec(V_MAX, V_MIN, 32'sh40000000);
    send_vec(V_MIN, V_MAX, -32'sh40000001);
    send_vec(32'sh3fffffff, '0, -32'sd1);

    // zero matrix, with a write to an unmapped index
    apply_quat('0, '0, '0, '0, 1'b1);
    send_vec(V_MAX, V_MIN, V_MAX);
    send_vec(32'sd7, -32'sd7, 32'sd1);

    // quarter turn about z, exercises rounding
    apply_quat(16'sd11585, '0, '0, 16'sd11585, 1'b0);
    send_vec(32'sh00010000, '0, '0);
    send_vec(32'sd1, 32'sd1, 32'sd1);
    send_vec(-32'sd1, -32'sd3, V_MAX);

    sent = 0;
    while (sent < 1200) begin
      case ($urandom_range(0, 7))
        0: begin
          qa = quat_t'($urandom);
          qb = quat_t'($urandom);
          qc = quat_t'($urandom);
          qd = quat_t'($urandom);
        end
        1: begin
          qa = quat_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
          qb = quat_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
          qc = $urandom_range(0, 1) ? QUAT_ONE : quat_t'(0);
          qd = quat_t'($urandom_range(0, 1) ? 16'sh8000 : 16'sh0000);
        end
        2: begin
          qa = QUAT_ONE;
          qb = '0;
          qc = '0;
          qd = '0;
        end
        default: random_unit(qa, qb, qc, qd);
      endcase
      apply_quat(qa, qb, qc, qd, $urandom_range(0, 3) == 0);
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(60, 140);
      repeat (n) send_vec(pick_comp(), pick_comp(), pick_comp());
      sent += n;
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.bad == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
